// ===== rtl/hrhp_pkg.sv =====
// package for the http request head parser: phase codes, field classes,
// error codes, header name tables and the result record
// no dependencies
package hrhp_pkg;

  localparam int MAX_REQUEST_BYTES = 4096;
  localparam int OFFSET_W = 12;
  localparam int OFFSET_CAP_INT = (MAX_REQUEST_BYTES - 1 < 4095) ? MAX_REQUEST_BYTES - 1 : 4095;
  localparam logic [OFFSET_W-1:0] OFFSET_CAP = OFFSET_CAP_INT[OFFSET_W-1:0];

  // parse phases
  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_TARGET  = 4'd1;
  localparam logic [3:0] PH_QUERY   = 4'd2;
  localparam logic [3:0] PH_VERSION = 4'd3;
  localparam logic [3:0] PH_HNAME   = 4'd4;
  localparam logic [3:0] PH_HSKIP   = 4'd5;
  localparam logic [3:0] PH_LENV    = 4'd6;
  localparam logic [3:0] PH_TYPEV   = 4'd7;
  localparam logic [3:0] PH_BODY    = 4'd8;
  localparam logic [3:0] PH_ERROR   = 4'd9;

  // field classes
  localparam logic [3:0] CLS_METHOD  = 4'd0;
  localparam logic [3:0] CLS_TARGET  = 4'd1;
  localparam logic [3:0] CLS_QUERY   = 4'd2;
  localparam logic [3:0] CLS_VERSION = 4'd3;
  localparam logic [3:0] CLS_SEP     = 4'd4;
  localparam logic [3:0] CLS_HEADER  = 4'd5;
  localparam logic [3:0] CLS_LENV    = 4'd6;
  localparam logic [3:0] CLS_TYPEV   = 4'd7;
  localparam logic [3:0] CLS_BLANK   = 4'd8;
  localparam logic [3:0] CLS_BODY    = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_LINEEND = 3'd1;
  localparam logic [2:0] ERR_NO_MSPACE  = 3'd2;
  localparam logic [2:0] ERR_NO_USPACE  = 3'd3;
  localparam logic [2:0] ERR_TRUNC      = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  localparam logic [4:0] LEN_NAME_SIZE  = 5'd16;
  localparam logic [4:0] TYPE_NAME_SIZE = 5'd14;
  localparam logic [4:0] IDX_MAX        = 5'd31;

  localparam logic [7:0] LEN_NAME [16] = '{
    "C", "o", "n", "t", "e", "n", "t", "-",
    "L", "e", "n", "g", "t", "h", ":", " "
  };
  // padded to 16, the tail is never matched
  localparam logic [7:0] TYPE_NAME [16] = '{
    "C", "o", "n", "t", "e", "n", "t", "-",
    "T", "y", "p", "e", ":", " ", 8'h00, 8'h00
  };

  typedef struct packed {
    logic [3:0]          field_class;
    logic [OFFSET_W-1:0] byte_offset;
    logic                line_end;
    logic                request_done;
    logic [2:0]          error_code;
  } res_t;

endpackage

// ===== rtl/http_request_head_parser_unit.sv =====
// http request head parser: tags each byte of a request head in one pass
// depends on hrhp_pkg
//
// Takes one request byte per cycle on the input channel while in_stall_o is
// low and returns one tagged result per byte, in order. A byte accepted at a
// clock edge has its result in the output register after that edge, or in the
// skid entry if the output register is held; the whole classification is a
// handful of constant-character compares and a phase update on the parse
// state register. An output register plus one skid entry decouple the two
// channels, so in_stall_o is registered and rises only when both are full.
// The parser returns to its start state after a byte flagged last_byte.
module http_request_head_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  field_class_o,
  output logic [11:0] byte_offset_o,
  output logic        line_end_o,
  output logic        request_done_o,
  output logic [2:0]  error_code_o
);

  logic [3:0]                   phase_q, phase_d;
  logic [hrhp_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [4:0]                   idx_q, idx_d;
  logic [1:0]                   cand_q, cand_d;
  logic                         crs_q, crs_d;
  logic [2:0]                   err_q, err_d;

  hrhp_pkg::res_t res;
  hrhp_pkg::res_t out_q, out_d;
  hrhp_pkg::res_t skid_q, skid_d;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;

  logic in_acc, out_acc;
  logic len_hit, type_hit;
  logic [1:0] cand_m;

  assign in_acc  = in_valid_i & ~skid_valid_q;
  assign out_acc = out_valid_q & ~out_stall_i;

  assign len_hit  = (idx_q < hrhp_pkg::LEN_NAME_SIZE) &&
                    (hrhp_pkg::LEN_NAME[idx_q[3:0]] == data_byte_i);
  assign type_hit = (idx_q < hrhp_pkg::TYPE_NAME_SIZE) &&
                    (hrhp_pkg::TYPE_NAME[idx_q[3:0]] == data_byte_i);
  assign cand_m   = {cand_q[1] & type_hit, cand_q[0] & len_hit};

  // parse step for one byte
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    cand_d  = cand_q;
    crs_d   = crs_q;
    err_d   = err_q;
    res.field_class  = hrhp_pkg::CLS_BODY;
    res.byte_offset  = offset_q;
    res.line_end     = 1'b0;
    res.request_done = 1'b0;

    if (phase_q >= hrhp_pkg::PH_BODY) begin
      res.field_class = hrhp_pkg::CLS_BODY;
    end else if (crs_q && data_byte_i == hrhp_pkg::CH_LF) begin
      crs_d = 1'b0;
      res.line_end = 1'b1;
      res.field_class = hrhp_pkg::CLS_SEP;
      unique case (phase_q)
        hrhp_pkg::PH_METHOD: begin
          err_d   = hrhp_pkg::ERR_NO_MSPACE;
          phase_d = hrhp_pkg::PH_ERROR;
        end
        hrhp_pkg::PH_TARGET, hrhp_pkg::PH_QUERY: begin
          err_d   = hrhp_pkg::ERR_NO_USPACE;
          phase_d = hrhp_pkg::PH_ERROR;
        end
        default: begin
          if (phase_q == hrhp_pkg::PH_HNAME && idx_q == '0) begin
            phase_d = hrhp_pkg::PH_BODY;
            res.request_done = 1'b1;
            res.field_class  = hrhp_pkg::CLS_BLANK;
          end else begin
            phase_d = hrhp_pkg::PH_HNAME;
            idx_d   = '0;
            cand_d  = 2'b11;
          end
        end
      endcase
    end else begin
      // a lone cr counts as content and ends the name match
      if (crs_q) begin
        crs_d = 1'b0;
        if (phase_q == hrhp_pkg::PH_HNAME) phase_d = hrhp_pkg::PH_HSKIP;
      end
      if (data_byte_i == hrhp_pkg::CH_CR) begin
        crs_d = 1'b1;
        res.field_class = (phase_d == hrhp_pkg::PH_HNAME && idx_q == '0) ?
                          hrhp_pkg::CLS_BLANK : hrhp_pkg::CLS_SEP;
      end else begin
        unique case (phase_d)
          hrhp_pkg::PH_METHOD: begin
            if (data_byte_i == hrhp_pkg::CH_SPACE) begin
              phase_d = hrhp_pkg::PH_TARGET;
              res.field_class = hrhp_pkg::CLS_SEP;
            end else begin
              res.field_class = hrhp_pkg::CLS_METHOD;
            end
          end
          hrhp_pkg::PH_TARGET: begin
            if (data_byte_i == hrhp_pkg::CH_SPACE) begin
              phase_d = hrhp_pkg::PH_VERSION;
              res.field_class = hrhp_pkg::CLS_SEP;
            end else if (data_byte_i == hrhp_pkg::CH_QMARK) begin
              phase_d = hrhp_pkg::PH_QUERY;
              res.field_class = hrhp_pkg::CLS_SEP;
            end else begin
              res.field_class = hrhp_pkg::CLS_TARGET;
            end
          end
          hrhp_pkg::PH_QUERY: begin
            if (data_byte_i == hrhp_pkg::CH_SPACE) begin
              phase_d = hrhp_pkg::PH_VERSION;
              res.field_class = hrhp_pkg::CLS_SEP;
            end else begin
              res.field_class = hrhp_pkg::CLS_QUERY;
            end
          end
          hrhp_pkg::PH_VERSION: res.field_class = hrhp_pkg::CLS_VERSION;
          hrhp_pkg::PH_HNAME: begin
            res.field_class = hrhp_pkg::CLS_HEADER;
            cand_d = cand_m;
            if (idx_q != hrhp_pkg::IDX_MAX) idx_d = idx_q + 5'd1;
            if (cand_m[0] && idx_q == hrhp_pkg::LEN_NAME_SIZE - 5'd1) begin
              phase_d = hrhp_pkg::PH_LENV;
            end else if (cand_m[1] && idx_q == hrhp_pkg::TYPE_NAME_SIZE - 5'd1) begin
              phase_d = hrhp_pkg::PH_TYPEV;
            end else if (cand_m == 2'b00) begin
              phase_d = hrhp_pkg::PH_HSKIP;
            end
          end
          hrhp_pkg::PH_LENV:  res.field_class = hrhp_pkg::CLS_LENV;
          hrhp_pkg::PH_TYPEV: res.field_class = hrhp_pkg::CLS_TYPEV;
          default:            res.field_class = hrhp_pkg::CLS_HEADER;
        endcase
      end
    end

    offset_d = (offset_q < hrhp_pkg::OFFSET_CAP) ? offset_q + hrhp_pkg::OFFSET_W'(1) :
                                                   offset_q;

    // end of buffer before the head is complete
    if (last_byte_i && err_d == hrhp_pkg::ERR_NONE && phase_d != hrhp_pkg::PH_BODY) begin
      err_d = (phase_d <= hrhp_pkg::PH_VERSION) ? hrhp_pkg::ERR_NO_LINEEND :
                                                  hrhp_pkg::ERR_TRUNC;
    end
    res.error_code = err_d;

    if (last_byte_i) begin
      phase_d  = hrhp_pkg::PH_METHOD;
      offset_d = '0;
      idx_d    = '0;
      cand_d   = 2'b11;
      crs_d    = 1'b0;
      err_d    = hrhp_pkg::ERR_NONE;
    end
  end

  // output register with one skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_acc || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hrhp_pkg::PH_METHOD;
      offset_q     <= '0;
      idx_q        <= '0;
      cand_q       <= 2'b11;
      crs_q        <= 1'b0;
      err_q        <= hrhp_pkg::ERR_NONE;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q  <= phase_d;
        offset_q <= offset_d;
        idx_q    <= idx_d;
        cand_q   <= cand_d;
        crs_q    <= crs_d;
        err_q    <= err_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign field_class_o  = out_q.field_class;
  assign byte_offset_o  = out_q.byte_offset;
  assign line_end_o     = out_q.line_end;
  assign request_done_o = out_q.request_done;
  assign error_code_o   = out_q.error_code;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_done_is_blank_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && request_done_o) |->
      (line_end_o && field_class_o == hrhp_pkg::CLS_BLANK))
    else $error("request done without blank line feed");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=>
      (phase_q == hrhp_pkg::PH_METHOD && offset_q == '0 && err_q == hrhp_pkg::ERR_NONE))
    else $error("parser did not restart after last byte");

  a_error_phase_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrhp_pkg::PH_ERROR) |-> (err_q != hrhp_pkg::ERR_NONE))
    else $error("error phase without error code");

endmodule
